/* rtl/ir_proximity_scan_sequencer_defines.svh */
// assertion helpers used by the checker file
`ifndef IR_PROXIMITY_SCAN_SEQUENCER_DEFINES_SVH
`define IR_PROXIMITY_SCAN_SEQUENCER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define IPSS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is high
`define IPSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ipss_pkg.sv */
package ipss_pkg;

   localparam int EMITTERS   = 4;
   localparam int ID_W       = $clog2(EMITTERS);
   localparam int LEN_W      = ID_W + 1;
   localparam int DUTY_W     = 8;
   localparam int CNT_W      = 16;
   localparam int PHASE_W    = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int OUT_DEPTH  = 3;
   localparam int OUT_PTR_W  = 2;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (ID_W + 3 + DUTY_W + PHASE_W + 1 + 2 * CNT_W);

   localparam logic [CNT_W-1:0] SAT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_TICK  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLE_MASK   = 2'd0,
      CSR_REPEAT_COUNT  = 2'd1,
      CSR_EMITTER_DUTY  = 2'd2
   } csr_idx_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_DUTY   = 3'd0,
      PH_EMIT   = 3'd1,
      PH_TX     = 3'd2,
      PH_SAMPLE = 3'd3,
      PH_OFF    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [ID_W-1:0]   emitter_select;
      logic              emitter_on;
      logic              tx_on;
      logic [DUTY_W-1:0] pwm_duty;
      phase_type         phase;
      logic              stopped;
   } status_type;

   typedef struct packed {
      logic            clear;
      logic            sample;
      logic            rx;
      logic            found;
      logic [ID_W-1:0] slot;
   } cnt_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] on_cnt;
      logic [CNT_W-1:0] off_cnt;
   } cnt_word_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [CNT_W-1:0] hits_on;
      logic [CNT_W-1:0] hits_off;
   } cnt_rsp_type;

   // first member sits in the top bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [CNT_W-1:0]     hits_off;
      logic [CNT_W-1:0]     hits_on;
      logic                 found;
      logic                 stopped;
      logic [PHASE_W-1:0]   phase;
      logic [DUTY_W-1:0]    pwm_duty;
      logic                 tx_on;
      logic                 emitter_on;
      logic [ID_W-1:0]      emitter_select;
   } rsp_type;

endpackage

/* rtl/ir_proximity_scan_sequencer.sv */
// path: a request beat's result passes the count unit's stage one registers, then
//   the result queue, before its result beat can be taken
// throughput: one item per cycle while the result queue has room; the count memory
//   read-modify-write spans stage one and write-back, forwarding between neighbours
// a three-deep result queue keeps taking requests while results wait, until it fills
// reset: synchronous, active high; halts the scan, clears counts and the queue
module ir_proximity_scan_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rx_detect, emitter_id, zero fill
   input  logic [ipss_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic [ipss_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // emitter_select, emitter_on, tx_on, pwm_duty, phase, stopped, found,
   // hits_on, hits_off, zero fill
   output logic [ipss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [ipss_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ipss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                               accept;
   ipss_pkg::status_type               status;
   ipss_pkg::cnt_req_type              cnt_req;
   ipss_pkg::cnt_rsp_type              cnt_rsp;
   ipss_pkg::rsp_type                  push_data;
   ipss_pkg::rsp_type                  head;
   logic [ipss_pkg::OUT_PTR_W-1:0]     count;
   logic [ipss_pkg::OUT_PTR_W:0]       in_flight;

   // every beat in flight owns a queue slot
   assign in_flight  = {1'b0, count} + {{ipss_pkg::OUT_PTR_W{1'b0}}, cnt_rsp.valid};
   assign req_tready = in_flight < (ipss_pkg::OUT_PTR_W + 1)'(ipss_pkg::OUT_DEPTH);
   assign accept     = req_tvalid && req_tready;

   ipss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .op        (ipss_pkg::op_type'(req_tuser)),
      .rx        (req_tdata[0]),
      .id        (req_tdata[ipss_pkg::ID_W:1]),
      .status    (status),
      .cnt_req   (cnt_req)
   );

   ipss_count_unit u_count (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (cnt_req),
      .rsp    (cnt_rsp)
   );

   // sequencer registers already hold the state left by the beat in stage one
   always_comb begin
      push_data                = '0;
      push_data.emitter_select = status.emitter_select;
      push_data.emitter_on     = status.emitter_on;
      push_data.tx_on          = status.tx_on;
      push_data.pwm_duty       = status.pwm_duty;
      push_data.phase          = status.phase;
      push_data.stopped        = status.stopped;
      push_data.found          = cnt_rsp.found;
      push_data.hits_on        = cnt_rsp.hits_on;
      push_data.hits_off       = cnt_rsp.hits_off;
   end

   ipss_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (cnt_rsp.valid),
      .push_data (push_data),
      .pop       (rsp_tvalid && rsp_tready),
      .head      (head),
      .count     (count)
   );

   assign rsp_tvalid = count != '0;
   assign rsp_tdata  = head;

endmodule

/* rtl/ipss_ctrl.sv */
module ipss_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ipss_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ipss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             accept,
   input  ipss_pkg::op_type                 op,
   input  logic                             rx,
   input  logic [ipss_pkg::ID_W-1:0]        id,
   output ipss_pkg::status_type             status,
   output ipss_pkg::cnt_req_type            cnt_req
);

   logic [ipss_pkg::EMITTERS-1:0]       enable_mask_ff;
   logic [7:0]                          repeat_count_ff;
   logic [ipss_pkg::CSR_DATA_W-1:0]     duties_ff;

   ipss_pkg::phase_type                 phase_ff, phase_in;
   logic                                halted_ff, halted_in;
   logic [ipss_pkg::ID_W-1:0]           list_ff [ipss_pkg::EMITTERS];
   logic [ipss_pkg::ID_W-1:0]           list_in [ipss_pkg::EMITTERS];
   logic [ipss_pkg::LEN_W-1:0]          length_ff, length_in;
   logic [ipss_pkg::ID_W-1:0]           pos_ff, pos_in;
   logic [7:0]                          repeats_ff, repeats_in;
   logic [ipss_pkg::DUTY_W-1:0]         duty_copy_ff [ipss_pkg::EMITTERS];
   logic [ipss_pkg::DUTY_W-1:0]         duty_copy_in [ipss_pkg::EMITTERS];
   logic                                emit_on_ff, emit_on_in;
   logic                                tx_on_ff, tx_on_in;
   logic [ipss_pkg::DUTY_W-1:0]         duty_ff, duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= '0;
         repeat_count_ff <= '0;
         duties_ff       <= '0;
      end else if (csr_we) begin
         case (ipss_pkg::csr_idx_type'(csr_addr))
            ipss_pkg::CSR_ENABLE_MASK:  enable_mask_ff  <= csr_wdata[ipss_pkg::EMITTERS-1:0];
            ipss_pkg::CSR_REPEAT_COUNT: repeat_count_ff <= csr_wdata[7:0];
            ipss_pkg::CSR_EMITTER_DUTY: duties_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ipss_pkg::PH_DUTY;
         halted_ff  <= 1'b1;
         length_ff  <= '0;
         pos_ff     <= '0;
         repeats_ff <= '0;
         emit_on_ff <= 1'b0;
         tx_on_ff   <= 1'b0;
         duty_ff    <= '0;
         for (int i = 0; i < ipss_pkg::EMITTERS; i++) begin
            list_ff[i]      <= '0;
            duty_copy_ff[i] <= '0;
         end
      end else begin
         phase_ff   <= phase_in;
         halted_ff  <= halted_in;
         length_ff  <= length_in;
         pos_ff     <= pos_in;
         repeats_ff <= repeats_in;
         emit_on_ff <= emit_on_in;
         tx_on_ff   <= tx_on_in;
         duty_ff    <= duty_in;
         for (int i = 0; i < ipss_pkg::EMITTERS; i++) begin
            list_ff[i]      <= list_in[i];
            duty_copy_ff[i] <= duty_copy_in[i];
         end
      end
   end

   always_comb begin
      logic [ipss_pkg::LEN_W-1:0] cnt;
      logic [ipss_pkg::LEN_W-1:0] pos_nx;
      phase_in   = phase_ff;
      halted_in  = halted_ff;
      length_in  = length_ff;
      pos_in     = pos_ff;
      repeats_in = repeats_ff;
      emit_on_in = emit_on_ff;
      tx_on_in   = tx_on_ff;
      duty_in    = duty_ff;
      list_in      = list_ff;
      duty_copy_in = duty_copy_ff;
      cnt     = '0;
      pos_nx  = {1'b0, pos_ff} + 1'b1;
      cnt_req = '0;

      if (accept) begin
         case (op)
            ipss_pkg::OP_START: begin
               // compact the mask into a list in rising order
               for (int i = 0; i < ipss_pkg::EMITTERS; i++) begin
                  duty_copy_in[i] = duties_ff[ipss_pkg::DUTY_W*i +: ipss_pkg::DUTY_W];
                  if (enable_mask_ff[i]) begin
                     list_in[cnt[ipss_pkg::ID_W-1:0]] = ipss_pkg::ID_W'(i);
                     cnt = cnt + 1'b1;
                  end
               end
               length_in     = cnt;
               pos_in        = '0;
               phase_in      = ipss_pkg::PH_DUTY;
               repeats_in    = repeat_count_ff;
               halted_in     = (cnt == '0);
               cnt_req.clear = 1'b1;
            end
            ipss_pkg::OP_TICK: begin
               if (!halted_ff) begin
                  case (phase_ff)
                     ipss_pkg::PH_DUTY: begin
                        duty_in  = duty_copy_ff[list_ff[pos_ff]];
                        phase_in = ipss_pkg::PH_EMIT;
                     end
                     ipss_pkg::PH_EMIT: begin
                        emit_on_in = 1'b1;
                        phase_in   = ipss_pkg::PH_TX;
                     end
                     ipss_pkg::PH_TX: begin
                        tx_on_in = 1'b1;
                        phase_in = ipss_pkg::PH_SAMPLE;
                     end
                     ipss_pkg::PH_SAMPLE: begin
                        cnt_req.sample = 1'b1;
                        cnt_req.rx     = rx;
                        cnt_req.slot   = pos_ff;
                        tx_on_in       = 1'b0;
                        phase_in       = ipss_pkg::PH_OFF;
                     end
                     default: begin
                        emit_on_in = 1'b0;
                        duty_in    = '0;
                        phase_in   = ipss_pkg::PH_DUTY;
                        if (pos_nx >= length_ff) begin
                           pos_in = '0;
                           if (repeats_ff != '0) begin
                              repeats_in = repeats_ff - 1'b1;
                              if (repeats_ff == 8'd1)
                                 halted_in = 1'b1;
                           end
                        end else begin
                           pos_in = pos_nx[ipss_pkg::ID_W-1:0];
                        end
                     end
                  endcase
               end
            end
            ipss_pkg::OP_READ: begin
               // downward sweep so the lowest matching slot wins
               for (int i = ipss_pkg::EMITTERS - 1; i >= 0; i--) begin
                  if (ipss_pkg::LEN_W'(i) < length_ff && list_ff[i] == id) begin
                     cnt_req.found = 1'b1;
                     cnt_req.slot  = ipss_pkg::ID_W'(i);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign status.emitter_select = list_ff[pos_ff];
   assign status.emitter_on     = emit_on_ff;
   assign status.tx_on          = tx_on_ff;
   assign status.pwm_duty       = duty_ff;
   assign status.phase          = phase_ff;
   assign status.stopped        = halted_ff;

endmodule

/* rtl/ipss_count_unit.sv */
module ipss_count_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ipss_pkg::cnt_req_type req,
   output ipss_pkg::cnt_rsp_type rsp
);

   ipss_pkg::cnt_word_type      cnt_mem [ipss_pkg::EMITTERS];
   ipss_pkg::cnt_word_type      rdata_ff;
   logic [ipss_pkg::EMITTERS-1:0] valid_ff;
   logic                        s1_act_ff;
   ipss_pkg::cnt_req_type       s1_req_ff;
   logic                        s1_slot_valid_ff;
   logic                        fwd_ff;
   ipss_pkg::cnt_word_type      fwd_data_ff;

   ipss_pkg::cnt_word_type      base;
   ipss_pkg::cnt_word_type      wr_data;
   logic                        wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         s1_act_ff <= 1'b0;
      end else begin
         s1_act_ff <= accept;
         // a start drops every slot back to zero counts
         if (accept && req.clear)
            valid_ff <= '0;
         else if (accept && req.sample)
            valid_ff[req.slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff         <= cnt_mem[req.slot];
         s1_req_ff        <= req;
         s1_slot_valid_ff <= valid_ff[req.slot];
         fwd_ff           <= wr_en && (s1_req_ff.slot == req.slot);
         fwd_data_ff      <= wr_data;
      end
      if (wr_en)
         cnt_mem[s1_req_ff.slot] <= wr_data;
   end

   always_comb begin
      if (fwd_ff)
         base = fwd_data_ff;
      else if (s1_slot_valid_ff)
         base = rdata_ff;
      else
         base = '0;
      wr_data = base;
      if (s1_req_ff.rx) begin
         if (base.on_cnt != ipss_pkg::SAT_MAX)
            wr_data.on_cnt = base.on_cnt + 1'b1;
      end else begin
         if (base.off_cnt != ipss_pkg::SAT_MAX)
            wr_data.off_cnt = base.off_cnt + 1'b1;
      end
   end

   assign wr_en        = s1_act_ff && s1_req_ff.sample;
   assign rsp.valid    = s1_act_ff;
   assign rsp.found    = s1_req_ff.found;
   assign rsp.hits_on  = s1_req_ff.found ? base.on_cnt : '0;
   assign rsp.hits_off = s1_req_ff.found ? base.off_cnt : '0;

endmodule

/* rtl/ipss_out_fifo.sv */
module ipss_out_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  ipss_pkg::rsp_type                push_data,
   input  logic                             pop,
   output ipss_pkg::rsp_type                head,
   output logic [ipss_pkg::OUT_PTR_W-1:0]   count
);

   ipss_pkg::rsp_type                  entry_ff [ipss_pkg::OUT_DEPTH];
   logic [ipss_pkg::OUT_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff, count_ff;

   function automatic logic [ipss_pkg::OUT_PTR_W-1:0] bump(
      input logic [ipss_pkg::OUT_PTR_W-1:0] p);
      if (p == ipss_pkg::OUT_PTR_W'(ipss_pkg::OUT_DEPTH - 1))
         return '0;
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)
            rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* rtl/ipss_checker.sv */
`include "ir_proximity_scan_sequencer_defines.svh"

module ipss_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ipss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   ipss_pkg::rsp_type rsp_view;
   logic              stall;
   logic              tx_shown;
   logic              stop_shown;
   logic              miss_shown;
   logic              idle_phase;
   logic              no_counts;

   assign rsp_view   = rsp_tdata;
   assign stall      = rsp_tvalid && !rsp_tready;
   assign tx_shown   = rsp_tvalid && rsp_view.tx_on;
   assign stop_shown = rsp_tvalid && rsp_view.stopped;
   assign miss_shown = rsp_tvalid && !rsp_view.found;
   assign idle_phase = rsp_view.phase == ipss_pkg::PH_DUTY;
   assign no_counts  = rsp_view.hits_on == '0 && rsp_view.hits_off == '0;

   `IPSS_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata), "beat changed")
   `IPSS_ASSERT_IMPLY(a_tx_emit, clock, reset, tx_shown, rsp_view.emitter_on, "tx without emitter")
   `IPSS_ASSERT_IMPLY(a_stop_phase, clock, reset, stop_shown, idle_phase, "halted mid phase")
   `IPSS_ASSERT_IMPLY(a_miss_zero, clock, reset, miss_shown, no_counts, "counts without a match")
   `IPSS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "beat offered out of reset")

endmodule

bind ir_proximity_scan_sequencer ipss_checker u_checker (.*);
